>>> sv/circle_pair_collision_response_core_macros.svh
// Assertion macros used by the collision response controller.
`ifndef CIRCLE_PAIR_COLLISION_RESPONSE_CORE_MACROS_SVH
`define CIRCLE_PAIR_COLLISION_RESPONSE_CORE_MACROS_SVH

// same-cycle implication
`define CPCR_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPCR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/cpcr_pkg.sv
// Shared types, widths and helpers of the collision response core.
package cpcr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TWO_ONE   = 2 ** (FRAC_BITS + 1);

   localparam int WW    = 40;
   localparam int HALF  = WW / 2;
   localparam int PW    = 2 * WW;
   localparam int DW    = 40;
   localparam int QW    = 40;
   localparam int SW    = 72;
   localparam int RW    = SW / 2;
   localparam int REMW  = RW + 2;
   localparam int EW    = 19;
   localparam int CNTW  = 6;

   typedef enum logic [3:0] {
      OP_SQX, OP_SQY, OP_C1, OP_C2, OP_CK, OP_PX, OP_PY,
      OP_K1, OP_K2, OP_VX1, OP_VY1, OP_VX2, OP_VY2
   } op_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [30:0]        radius;
      logic [30:0]        mass;
      logic [16:0]        elasticity;
      logic               is_fixed;
   } particle_type;

   typedef struct packed {
      logic   load1;
      logic   load2;
      logic   prep;
      logic   mul_lo;
      logic   mul_hi;
      logic   acc_s;
      logic   sqrt_init;
      logic   sqrt_step;
      logic   div_init;
      logic   div_step;
      logic   write;
      logic   out_sel;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic pass;
   } status_type;

   function automatic logic [31:0] sat32(input logic signed [WW-1:0] v);
      logic [31:0] r;
      if (!v[WW-1] && (|v[WW-2:31])) begin
         r = 32'h7fffffff;
      end else if (v[WW-1] && !(&v[WW-2:31])) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> sv/circle_pair_collision_response_core.sv
// Top level of the circle pair collision response core.
// Particles arrive one request at a time; a request with tlast low is held,
// and the following request with tlast high resolves the pair and yields two
// results, first particle then second. A resolving request passes through two
// squares and a 36-step square root, then eleven scaled divisions that share
// one 40x20 multiplier (two passes) and one radix-2 divider (40 steps each).
// Pairs with coinciding centres or two fixed particles go from the prep and
// decide states straight to their first result, skipping the arithmetic.
// No request is taken until both results have been delivered.
module circle_pair_collision_response_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // pos_x, pos_y, vel_x, vel_y, radius, mass, elasticity, zero pad
   input  logic [207:0]  req_tdata,
   // is_fixed
   input  logic          req_tuser,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // new_pos_x, new_pos_y, new_vel_x, new_vel_y
   output logic [127:0]  rsp_tdata,
   // particle_index, centres_coincide
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast
);
   cpcr_pkg::particle_type req_part;
   cpcr_pkg::cmd_type      cmd;
   cpcr_pkg::status_type   status;
   logic [31:0]            out_pos_x, out_pos_y, out_vel_x, out_vel_y;
   logic                   out_coincide, out_index;

   assign req_part.pos_x      = req_tdata[31:0];
   assign req_part.pos_y      = req_tdata[63:32];
   assign req_part.vel_x      = req_tdata[95:64];
   assign req_part.vel_y      = req_tdata[127:96];
   assign req_part.radius     = req_tdata[158:128];
   assign req_part.mass       = req_tdata[189:159];
   assign req_part.elasticity = req_tdata[206:190];
   assign req_part.is_fixed   = req_tuser;

   cpcr_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_index  (out_index),
      .cmd        (cmd),
      .status     (status)
   );

   cpcr_datapath u_dp (
      .clock        (clock),
      .req_part     (req_part),
      .cmd          (cmd),
      .status       (status),
      .out_pos_x    (out_pos_x),
      .out_pos_y    (out_pos_y),
      .out_vel_x    (out_vel_x),
      .out_vel_y    (out_vel_y),
      .out_coincide (out_coincide)
   );

   assign rsp_tdata = {out_vel_y, out_vel_x, out_pos_y, out_pos_x};
   assign rsp_tuser = {out_coincide, out_index};
   assign rsp_tlast = out_index;

endmodule

>>> sv/cpcr_datapath.sv
// Datapath: particle registers, shared multiplier, root and divide steps.
module cpcr_datapath (
   input  logic                   clock,
   input  cpcr_pkg::particle_type req_part,
   input  cpcr_pkg::cmd_type      cmd,
   output cpcr_pkg::status_type   status,
   output logic [31:0]            out_pos_x,
   output logic [31:0]            out_pos_y,
   output logic [31:0]            out_vel_x,
   output logic [31:0]            out_vel_y,
   output logic                   out_coincide
);
   localparam int WW   = cpcr_pkg::WW;
   localparam int HALF = cpcr_pkg::HALF;
   localparam int PW   = cpcr_pkg::PW;
   localparam int DW   = cpcr_pkg::DW;
   localparam int QW   = cpcr_pkg::QW;
   localparam int SW   = cpcr_pkg::SW;
   localparam int RW   = cpcr_pkg::RW;
   localparam int REMW = cpcr_pkg::REMW;
   localparam int EW   = cpcr_pkg::EW;

   logic signed [WW-1:0] x1_ff, y1_ff, vx1_ff, vy1_ff, x2_ff, y2_ff, vx2_ff, vy2_ff;
   logic [30:0]          r1_ff, r2_ff, m1_ff, m2_ff;
   logic [16:0]          e1_ff, e2_ff;
   logic                 f1_ff, f2_ff, coin_ff;
   logic signed [WW-1:0] dx_ff, dy_ff, dvx_ff, dvy_ff;
   logic [EW-1:0]        e_ff;
   logic [32:0]          msum_ff;
   logic [SW-1:0]        s_ff;
   logic [RW-1:0]        root_ff;
   logic [REMW-1:0]      rem_s_ff;
   logic [PW-1:0]        prod_ff;
   logic [DW-1:0]        rem_ff;
   logic [QW-1:0]        quo_ff;
   logic signed [WW-1:0] c_ff, ck_ff, k1_ff, k2_ff;

   logic signed [WW-1:0] ov, a_op, b_op, q_s, res;
   logic [WW-1:0]        a_mag, b_mag;
   logic [HALF-1:0]      b_half;
   logic [WW+HALF-1:0]   mul_p;
   logic [DW-1:0]        d_op;
   logic                 both_move, msum_zero;
   logic [REMW+1:0]      rsq_sh, rsq_trial;
   logic                 rsq_ge;
   logic [DW:0]          div_sh;
   logic                 div_ge;

   assign ov        = WW'(r1_ff) + WW'(r2_ff) - WW'(root_ff);
   assign both_move = !f1_ff && !f2_ff;
   assign msum_zero = (msum_ff == '0);

   always_comb begin
      a_op = dx_ff;
      b_op = dx_ff;
      d_op = DW'(root_ff);
      case (cmd.op)
         cpcr_pkg::OP_SQX: begin
            a_op = dx_ff; b_op = dx_ff;
         end
         cpcr_pkg::OP_SQY: begin
            a_op = dy_ff; b_op = dy_ff;
         end
         cpcr_pkg::OP_C1: begin
            a_op = dvx_ff; b_op = dx_ff;
         end
         cpcr_pkg::OP_C2: begin
            a_op = dvy_ff; b_op = dy_ff;
         end
         cpcr_pkg::OP_CK: begin
            a_op = c_ff; b_op = WW'(e_ff); d_op = DW'(cpcr_pkg::TWO_ONE);
         end
         cpcr_pkg::OP_PX, cpcr_pkg::OP_PY: begin
            a_op = (cmd.op == cpcr_pkg::OP_PX) ? dx_ff : dy_ff;
            b_op = ov;
            d_op = both_move ? DW'({root_ff, 1'b0}) : DW'(root_ff);
         end
         cpcr_pkg::OP_K1, cpcr_pkg::OP_K2: begin
            a_op = ck_ff;
            if (msum_zero) begin
               b_op = WW'(1);
               d_op = DW'(2);
            end else begin
               b_op = (cmd.op == cpcr_pkg::OP_K1) ? WW'(m2_ff) : WW'(m1_ff);
               d_op = DW'(msum_ff);
            end
         end
         cpcr_pkg::OP_VX1, cpcr_pkg::OP_VY1: begin
            a_op = (cmd.op == cpcr_pkg::OP_VX1) ? dx_ff : dy_ff;
            b_op = both_move ? k1_ff : ck_ff;
         end
         cpcr_pkg::OP_VX2, cpcr_pkg::OP_VY2: begin
            a_op = (cmd.op == cpcr_pkg::OP_VX2) ? dx_ff : dy_ff;
            b_op = both_move ? k2_ff : ck_ff;
         end
         default: begin
            a_op = dx_ff;
         end
      endcase
   end

   assign a_mag = a_op[WW-1] ? WW'(-a_op) : WW'(a_op);
   assign b_mag = b_op[WW-1] ? WW'(-b_op) : WW'(b_op);
   assign q_s   = WW'(quo_ff);
   assign res   = (a_op[WW-1] ^ b_op[WW-1]) ? -q_s : q_s;

   assign b_half = cmd.mul_hi ? b_mag[WW-1:HALF] : b_mag[HALF-1:0];
   assign mul_p  = a_mag * b_half;

   assign rsq_sh    = {rem_s_ff, s_ff[SW-1 -: 2]};
   assign rsq_trial = (REMW + 2)'({root_ff, 2'b01});
   assign rsq_ge    = (rsq_sh >= rsq_trial);

   assign div_sh = {rem_ff, prod_ff[PW-1]};
   assign div_ge = (div_sh >= {1'b0, d_op});

   always_ff @(posedge clock) begin
      if (cmd.load1) begin
         x1_ff  <= WW'(req_part.pos_x);
         y1_ff  <= WW'(req_part.pos_y);
         vx1_ff <= WW'(req_part.vel_x);
         vy1_ff <= WW'(req_part.vel_y);
         r1_ff  <= req_part.radius;
         m1_ff  <= req_part.mass;
         e1_ff  <= req_part.elasticity;
         f1_ff  <= req_part.is_fixed;
      end
      if (cmd.load2) begin
         x2_ff  <= WW'(req_part.pos_x);
         y2_ff  <= WW'(req_part.pos_y);
         vx2_ff <= WW'(req_part.vel_x);
         vy2_ff <= WW'(req_part.vel_y);
         r2_ff  <= req_part.radius;
         m2_ff  <= req_part.mass;
         e2_ff  <= req_part.elasticity;
         f2_ff  <= req_part.is_fixed;
      end
      if (cmd.prep) begin
         dx_ff   <= x1_ff - x2_ff;
         dy_ff   <= y1_ff - y2_ff;
         dvx_ff  <= vx1_ff - vx2_ff;
         dvy_ff  <= vy1_ff - vy2_ff;
         e_ff    <= EW'(cpcr_pkg::TWO_ONE) + EW'(e1_ff) + EW'(e2_ff);
         msum_ff <= 33'(m1_ff) + 33'(m2_ff);
         coin_ff <= (x1_ff == x2_ff) && (y1_ff == y2_ff);
         s_ff    <= '0;
      end
      if (cmd.mul_lo) begin
         prod_ff <= PW'(mul_p);
      end
      if (cmd.mul_hi) begin
         prod_ff <= prod_ff + (PW'(mul_p) << HALF);
      end
      if (cmd.acc_s) begin
         s_ff <= s_ff + SW'(prod_ff);
      end
      if (cmd.sqrt_init) begin
         root_ff  <= '0;
         rem_s_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         rem_s_ff <= REMW'(rsq_ge ? rsq_sh - rsq_trial : rsq_sh);
         root_ff  <= {root_ff[RW-2:0], rsq_ge};
         s_ff     <= s_ff << 2;
      end
      if (cmd.div_init) begin
         rem_ff  <= prod_ff[PW-1 -: DW];
         prod_ff <= {prod_ff[PW-DW-1:0], DW'(0)};
         quo_ff  <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= DW'(div_ge ? div_sh - {1'b0, d_op} : div_sh);
         prod_ff <= prod_ff << 1;
         quo_ff  <= {quo_ff[QW-2:0], div_ge};
      end
      if (cmd.write) begin
         case (cmd.op)
            cpcr_pkg::OP_C1: c_ff  <= res;
            cpcr_pkg::OP_C2: c_ff  <= c_ff + res;
            cpcr_pkg::OP_CK: ck_ff <= res;
            cpcr_pkg::OP_K1: k1_ff <= res;
            cpcr_pkg::OP_K2: k2_ff <= res;
            cpcr_pkg::OP_PX: begin
               if (!f1_ff) x1_ff <= x1_ff + res;
               if (!f2_ff) x2_ff <= x2_ff - res;
            end
            cpcr_pkg::OP_PY: begin
               if (!f1_ff) y1_ff <= y1_ff + res;
               if (!f2_ff) y2_ff <= y2_ff - res;
            end
            cpcr_pkg::OP_VX1: vx1_ff <= f1_ff ? '0 : vx1_ff - res;
            cpcr_pkg::OP_VY1: vy1_ff <= f1_ff ? '0 : vy1_ff - res;
            cpcr_pkg::OP_VX2: vx2_ff <= f2_ff ? '0 : vx2_ff + res;
            cpcr_pkg::OP_VY2: vy2_ff <= f2_ff ? '0 : vy2_ff + res;
            default: c_ff <= c_ff;
         endcase
      end
   end

   assign status.pass  = coin_ff || (f1_ff && f2_ff);
   assign out_coincide = coin_ff;
   assign out_pos_x = cpcr_pkg::sat32(cmd.out_sel ? x2_ff : x1_ff);
   assign out_pos_y = cpcr_pkg::sat32(cmd.out_sel ? y2_ff : y1_ff);
   assign out_vel_x = cpcr_pkg::sat32(cmd.out_sel ? vx2_ff : vx1_ff);
   assign out_vel_y = cpcr_pkg::sat32(cmd.out_sel ? vy2_ff : vy1_ff);

endmodule

>>> sv/cpcr_controller.sv
// Controller: pair tracking and sequencing of the shared arithmetic.
`include "circle_pair_collision_response_core_macros.svh"

module cpcr_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic                 out_index,
   output cpcr_pkg::cmd_type    cmd,
   input  cpcr_pkg::status_type status
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_DECIDE, ST_MUL_LO, ST_MUL_HI, ST_ACC,
      ST_SQRT_INIT, ST_SQRT, ST_DIV_INIT, ST_DIV, ST_WRITE, ST_OUT0, ST_OUT1
   } state_type;

   state_type                   state_ff;
   logic                        held_ff;
   cpcr_pkg::op_type            op_ff;
   logic [cpcr_pkg::CNTW-1:0]   cnt_ff;
   logic                        req_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_OUT0) || (state_ff == ST_OUT1);
   assign out_index  = (state_ff == ST_OUT1);

   always_comb begin
      cmd           = '0;
      cmd.op        = op_ff;
      cmd.load1     = req_acc && !req_tlast;
      cmd.load2     = req_acc && req_tlast && held_ff;
      cmd.prep      = (state_ff == ST_PREP);
      cmd.mul_lo    = (state_ff == ST_MUL_LO);
      cmd.mul_hi    = (state_ff == ST_MUL_HI);
      cmd.acc_s     = (state_ff == ST_ACC);
      cmd.sqrt_init = (state_ff == ST_SQRT_INIT);
      cmd.sqrt_step = (state_ff == ST_SQRT);
      cmd.div_init  = (state_ff == ST_DIV_INIT);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.write     = (state_ff == ST_WRITE);
      cmd.out_sel   = out_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff  <= 1'b0;
         op_ff    <= cpcr_pkg::OP_SQX;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (!req_tlast) begin
                     held_ff <= 1'b1;
                  end else if (held_ff) begin
                     held_ff  <= 1'b0;
                     state_ff <= ST_PREP;
                  end
               end
            end
            ST_PREP: state_ff <= ST_DECIDE;
            ST_DECIDE: begin
               op_ff    <= cpcr_pkg::OP_SQX;
               state_ff <= status.pass ? ST_OUT0 : ST_MUL_LO;
            end
            ST_MUL_LO: state_ff <= ST_MUL_HI;
            ST_MUL_HI: begin
               if (op_ff == cpcr_pkg::OP_SQX || op_ff == cpcr_pkg::OP_SQY) begin
                  state_ff <= ST_ACC;
               end else begin
                  state_ff <= ST_DIV_INIT;
               end
            end
            ST_ACC: begin
               if (op_ff == cpcr_pkg::OP_SQY) begin
                  state_ff <= ST_SQRT_INIT;
               end else begin
                  op_ff    <= cpcr_pkg::OP_SQY;
                  state_ff <= ST_MUL_LO;
               end
            end
            ST_SQRT_INIT: begin
               cnt_ff   <= '0;
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == cpcr_pkg::CNTW'(cpcr_pkg::RW - 1)) begin
                  op_ff    <= cpcr_pkg::OP_C1;
                  state_ff <= ST_MUL_LO;
               end
            end
            ST_DIV_INIT: begin
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == cpcr_pkg::CNTW'(cpcr_pkg::QW - 1)) begin
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               if (op_ff == cpcr_pkg::OP_VY2) begin
                  state_ff <= ST_OUT0;
               end else begin
                  op_ff    <= cpcr_pkg::op_type'(4'(op_ff) + 4'd1);
                  state_ff <= ST_MUL_LO;
               end
            end
            ST_OUT0: if (rsp_tready) state_ff <= ST_OUT1;
            ST_OUT1: if (rsp_tready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `CPCR_ASSERT_IMPLIES(a_no_request_while_emitting, clock, reset, rsp_tvalid, !req_tready, "request taken while results pending")
   `CPCR_ASSERT_NEXT(a_second_follows_first, clock, reset, rsp_tvalid && rsp_tready && !out_index, rsp_tvalid && out_index, "second result missing")
   `CPCR_ASSERT_IMPLIES(a_held_drops_on_pair, clock, reset, $fell(held_ff) && !$past(reset), $past(req_tvalid && req_tready && req_tlast), "held particle lost")

endmodule
